// ===== hdl/pgn_dt_pkg.sv =====
`timescale 1ns / 1ps

package pgn_dt_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int MASK_W    = 8;
   localparam int PGN_W     = 18;
   localparam int ID_W      = 29;
   localparam int ADDR_W    = 8;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam logic [7:0] PDU2_CUTOFF = 8'hF0;
   localparam logic [7:0] BROADCAST   = 8'hFF;
   localparam logic [7:0] SLOT_NONE   = 8'hFF;
   localparam int ID_EDP_BIT = 25;
   localparam int ID_DP_BIT  = 24;

   typedef enum logic [1:0] {
      MODE_RECEIVE    = 2'd0,
      MODE_REGISTER   = 2'd1,
      MODE_UNREGISTER = 2'd2,
      MODE_UNUSED     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_BAD_SLOT = 2'd2,
      STAT_FILTERED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] slot_in;
      logic [PGN_W-1:0]  pgn_in;
      logic              is_extended;
      logic [ID_W-1:0]   can_id;
   } req_data_type;

   typedef struct packed {
      logic [ADDR_W-1:0] destination_address;
      logic [ADDR_W-1:0] source_address;
      logic [PGN_W-1:0]  frame_pgn;
      logic              unhandled;
      logic [MASK_W-1:0] hit_mask;
      logic [ADDR_W-1:0] slot_id;
      status_type        status;
   } rsp_data_type;

endpackage

// ===== hdl/pgn_dispatch_table_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload (lowest bit first)
// req_      in         tuser: mode; tdata: can_id, is_extended, pgn_in, slot_in
// rsp_      out        tdata: status, slot_id, hit_mask, unhandled, frame_pgn,
//                             source_address, destination_address
//
// One request is worked at a time. A receive request walks the PGN memory at one
// slot read per cycle. A register request checks one used flag per cycle until it
// finds a free slot or reaches the last slot. Unregister, filtered frames and the
// unused mode go straight to the done state without a walk.
// Reset is synchronous and clears every used flag at once. A result waits in the
// output register while the next request is accepted and worked.
module pgn_dispatch_table_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_tuser,  // mode
   // can_id, is_extended, pgn_in, slot_in
   input  logic [pgn_dt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, slot_id, hit_mask, unhandled, frame_pgn, source_address,
   // destination_address, zero fill
   output logic [pgn_dt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int N      = pgn_dt_pkg::NUM_SLOTS;
   localparam int SW     = pgn_dt_pkg::SLOT_W;
   localparam int CW     = pgn_dt_pkg::CNT_W;
   localparam int PW     = pgn_dt_pkg::PGN_W;
   localparam int RSP_W  = $bits(pgn_dt_pkg::rsp_data_type);

   pgn_dt_pkg::state_type    state_ff, state_in;
   pgn_dt_pkg::mode_type     mode_ff, mode_in;
   pgn_dt_pkg::req_data_type req_ff, req_in, req_now;
   pgn_dt_pkg::rsp_data_type rsp_now;

   logic [N-1:0]                   used_ff, used_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [SW-1:0]                  cmp_idx_ff, cmp_idx_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic                           hit_any_ff, hit_any_in;
   logic [pgn_dt_pkg::MASK_W-1:0]  mask_ff, mask_in;
   logic                           found_ff, found_in;
   logic [SW-1:0]                  found_slot_ff, found_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]               rsp_data_ff, rsp_data_in;

   logic [PW-1:0] pgn_mem [N];
   logic [PW-1:0] rd_data_ff;

   logic          accept;
   logic          load;
   logic          in_filtered;
   logic          mem_rd;
   logic          mem_wr;
   logic [SW-1:0] scan_slot;
   logic          slot_free;
   logic          scan_last;
   logic          scan_end;
   logic          cmp_hit;

   logic          frame_filtered;
   logic [7:0]    frame_pf;
   logic          frame_pdu1;
   logic [PW-1:0] frame_pgn;
   logic          unreg_ok;
   logic [SW-1:0] unreg_slot;

   assign req_now     = pgn_dt_pkg::req_data_type'(req_tdata);
   assign accept      = req_tvalid && req_tready;
   assign in_filtered = !req_now.is_extended || req_now.can_id[pgn_dt_pkg::ID_EDP_BIT];

   assign scan_slot = idx_ff[SW-1:0];
   assign slot_free = !used_ff[scan_slot];
   assign scan_last = (idx_ff == CW'(N - 1));
   assign scan_end  = (idx_ff == CW'(N));
   assign cmp_hit   = cmp_vld_ff && used_ff[cmp_idx_ff] && (rd_data_ff == frame_pgn);

   assign frame_filtered = !req_ff.is_extended || req_ff.can_id[pgn_dt_pkg::ID_EDP_BIT];
   assign frame_pf       = req_ff.can_id[23:16];
   assign frame_pdu1     = frame_pf < pgn_dt_pkg::PDU2_CUTOFF;
   assign frame_pgn      = {req_ff.can_id[pgn_dt_pkg::ID_EDP_BIT],
                            req_ff.can_id[pgn_dt_pkg::ID_DP_BIT], frame_pf,
                            frame_pdu1 ? 8'h00 : req_ff.can_id[15:8]};
   assign unreg_slot     = req_ff.slot_in[SW-1:0];
   assign unreg_ok       = (req_ff.slot_in < 8'(N)) && used_ff[unreg_slot];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgn_dt_pkg::ST_IDLE: begin
            if (accept) begin
               if ((pgn_dt_pkg::mode_type'(req_tuser) == pgn_dt_pkg::MODE_RECEIVE
                    && !in_filtered)
                   || pgn_dt_pkg::mode_type'(req_tuser) == pgn_dt_pkg::MODE_REGISTER) begin
                  state_in = pgn_dt_pkg::ST_SCAN;
               end else begin
                  state_in = pgn_dt_pkg::ST_DONE;
               end
            end
         end
         pgn_dt_pkg::ST_SCAN: begin
            if (mode_ff == pgn_dt_pkg::MODE_REGISTER) begin
               if (slot_free || scan_last) begin
                  state_in = pgn_dt_pkg::ST_DONE;
               end
            end else if (scan_end) begin
               state_in = pgn_dt_pkg::ST_DONE;
            end
         end
         pgn_dt_pkg::ST_DONE: begin
            if (load) begin
               state_in = pgn_dt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pgn_dt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load       = 1'b0;
      mem_rd     = 1'b0;
      mem_wr     = 1'b0;
      case (state_ff)
         pgn_dt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         pgn_dt_pkg::ST_SCAN: begin
            if (mode_ff == pgn_dt_pkg::MODE_REGISTER) begin
               mem_wr = slot_free;
            end else begin
               mem_rd = !scan_end;
            end
         end
         pgn_dt_pkg::ST_DONE: begin
            load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_now        = '0;
      rsp_now.status = pgn_dt_pkg::STAT_OK;
      case (mode_ff)
         pgn_dt_pkg::MODE_RECEIVE: begin
            if (frame_filtered) begin
               rsp_now.status = pgn_dt_pkg::STAT_FILTERED;
            end else begin
               rsp_now.hit_mask            = mask_ff;
               rsp_now.unhandled           = !hit_any_ff;
               rsp_now.frame_pgn           = frame_pgn;
               rsp_now.source_address      = req_ff.can_id[7:0];
               rsp_now.destination_address = frame_pdu1 ? req_ff.can_id[15:8]
                                                        : pgn_dt_pkg::BROADCAST;
            end
         end
         pgn_dt_pkg::MODE_REGISTER: begin
            if (found_ff) begin
               rsp_now.slot_id = 8'(found_slot_ff);
            end else begin
               rsp_now.status  = pgn_dt_pkg::STAT_FULL;
               rsp_now.slot_id = pgn_dt_pkg::SLOT_NONE;
            end
         end
         pgn_dt_pkg::MODE_UNREGISTER: begin
            if (!unreg_ok) begin
               rsp_now.status = pgn_dt_pkg::STAT_BAD_SLOT;
            end
         end
         default: begin
            rsp_now = '0;
         end
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      req_in        = req_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      cmp_idx_in    = scan_slot;
      cmp_vld_in    = mem_rd;
      hit_any_in    = hit_any_ff;
      mask_in       = mask_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (accept) begin
         mode_in    = pgn_dt_pkg::mode_type'(req_tuser);
         req_in     = req_now;
         idx_in     = '0;
         hit_any_in = 1'b0;
         mask_in    = '0;
         found_in   = 1'b0;
      end

      if (state_ff == pgn_dt_pkg::ST_SCAN) begin
         idx_in = idx_ff + CW'(1);
         if (mem_wr) begin
            used_in[scan_slot] = 1'b1;
            found_in           = 1'b1;
            found_slot_in      = scan_slot;
         end
      end

      if (cmp_hit) begin
         hit_any_in = 1'b1;
         for (int j = 0; j < pgn_dt_pkg::MASK_W; j++) begin
            if (int'(cmp_idx_ff) == j) begin
               mask_in[j] = 1'b1;
            end
         end
      end

      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_now;
         if (mode_ff == pgn_dt_pkg::MODE_UNREGISTER && unreg_ok) begin
            used_in[unreg_slot] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgn_dt_pkg::ST_IDLE;
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_any_ff    <= hit_any_in;
      mask_ff       <= mask_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         pgn_mem[scan_slot] <= req_ff.pgn_in;
      end
      if (mem_rd) begin
         rd_data_ff <= pgn_mem[scan_slot];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pgn_dt_pkg::RSP_DATA_W'(rsp_data_ff);

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pgn_dt_pkg::ST_SCAN && mode_ff == pgn_dt_pkg::MODE_RECEIVE)
      |=> $stable(used_ff))
      else $error("Used flags changed during a receive walk.");

   assert property (@(posedge clock) disable iff (reset)
      (load && mode_ff == pgn_dt_pkg::MODE_REGISTER && found_ff)
      |=> used_ff[$past(found_slot_ff)])
      else $error("Registered slot is not marked used.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[17:10] != 8'h00) |-> !rsp_data_ff[18])
      else $error("Frame with slot hits is reported as unhandled.");
`endif

endmodule

// ===== verif/tb_pgn_dispatch_table_core.sv =====
`timescale 1ns / 1ps

module tb_pgn_dispatch_table_core;
   import pgn_dt_pkg::*;

   localparam int RANDOM_ITEMS  = 850;
   localparam int POOL_SIZE     = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 2 * (NUM_SLOTS + 3);
   localparam int RSP_FIELDS_W  = $bits(rsp_data_type);

   typedef struct {
      mode_type     mode;
      req_data_type request;
      logic         fixed;
      rsp_data_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser  = MODE_RECEIVE;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bit               slot_taken [NUM_SLOTS];
   logic [PGN_W-1:0] slot_group [NUM_SLOTS];
   logic [PGN_W-1:0] group_pool [POOL_SIZE];

   rsp_data_type pending_responses[$];
   stim_row_type directed_rows[$];

   int fail_count        = 0;
   int requests_sent     = 0;
   int hits_seen         = 0;
   int unhandled_seen    = 0;
   int filtered_seen     = 0;
   int full_seen         = 0;
   int bad_slot_seen     = 0;
   int sender_idle_pct   = 38;
   int receiver_idle_pct = 46;
   int stall_cycles      = 0;

   pgn_dispatch_table_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_data_type dispatch_result(mode_type mode, req_data_type rq);
      rsp_data_type     r;
      logic [7:0]       pf;
      logic [PGN_W-1:0] fpgn;
      logic             found;
      r = '0;
      found = 1'b0;
      case (mode)
         MODE_RECEIVE: begin
            if (!rq.is_extended || rq.can_id[ID_EDP_BIT]) begin
               r.status = STAT_FILTERED;
               filtered_seen++;
            end else begin
               pf = rq.can_id[23:16];
               fpgn = {rq.can_id[ID_EDP_BIT], rq.can_id[ID_DP_BIT], pf,
                       (pf < PDU2_CUTOFF) ? 8'h00 : rq.can_id[15:8]};
               for (int k = 0; k < NUM_SLOTS; k++) begin
                  if (slot_taken[k] && slot_group[k] == fpgn) begin
                     found = 1'b1;
                     if (k < MASK_W) r.hit_mask[k] = 1'b1;
                  end
               end
               r.unhandled = !found;
               r.frame_pgn = fpgn;
               r.source_address = rq.can_id[7:0];
               r.destination_address = (pf < PDU2_CUTOFF) ? rq.can_id[15:8] : BROADCAST;
               if (found) hits_seen++;
               else unhandled_seen++;
            end
         end
         MODE_REGISTER: begin
            for (int k = 0; k < NUM_SLOTS && !found; k++) begin
               if (!slot_taken[k]) begin
                  slot_taken[k] = 1'b1;
                  slot_group[k] = rq.pgn_in;
                  r.slot_id = 8'(k);
                  found = 1'b1;
               end
            end
            if (!found) begin
               r.status = STAT_FULL;
               r.slot_id = SLOT_NONE;
               full_seen++;
            end
         end
         MODE_UNREGISTER: begin
            if (rq.slot_in < NUM_SLOTS && slot_taken[rq.slot_in[SLOT_W-1:0]]) begin
               slot_taken[rq.slot_in[SLOT_W-1:0]] = 1'b0;
               slot_group[rq.slot_in[SLOT_W-1:0]] = '0;
            end else begin
               r.status = STAT_BAD_SLOT;
               bad_slot_seen++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_row(mode_type m, logic [ID_W-1:0] id, logic ext, logic [PGN_W-1:0] pgn,
                          logic [7:0] slot, logic fixed, status_type st, logic [7:0] sid);
      stim_row_type row;
      row.mode = m;
      row.request.can_id = id;
      row.request.is_extended = ext;
      row.request.pgn_in = pgn;
      row.request.slot_in = slot;
      row.fixed = fixed;
      row.want = '0;
      row.want.status = st;
      row.want.slot_id = sid;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(mode_type m, req_data_type rq, logic fixed, rsp_data_type want);
      rsp_data_type predicted;
      req_tuser <= m;
      req_tdata <= rq;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = dispatch_result(m, rq);
      pending_responses.push_back(fixed ? want : predicted);
      requests_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_all_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   task automatic make_random(output mode_type m, output req_data_type rq);
      logic [63:0]      noise;
      logic [PGN_W-1:0] g;
      int               pick;
      noise = {$urandom, $urandom};
      rq = noise[REQ_DATA_W-1:0];
      g = group_pool[$urandom_range(POOL_SIZE - 1)];
      pick = $urandom_range(99);
      if (pick < 45) begin
         m = MODE_RECEIVE;
         if ($urandom_range(9) < 7) begin
            rq.can_id[ID_EDP_BIT] = g[17];
            rq.can_id[ID_DP_BIT] = g[16];
            rq.can_id[23:16] = g[15:8];
            if (g[15:8] >= PDU2_CUTOFF) rq.can_id[15:8] = g[7:0];
            rq.is_extended = ($urandom_range(9) != 0);
         end
      end else if (pick < 70) begin
         m = MODE_REGISTER;
         if ($urandom_range(4) != 0) rq.pgn_in = g;
      end else if (pick < 95) begin
         m = MODE_UNREGISTER;
         if ($urandom_range(4) != 0) rq.slot_in = 8'($urandom_range(NUM_SLOTS - 1));
      end else begin
         m = MODE_UNUSED;
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : response_check
      rsp_data_type got;
      rsp_data_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_FIELDS_W-1:0];
            if (pending_responses.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = pending_responses.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("slot_id", 32'(want.slot_id), 32'(got.slot_id));
               check_field("hit_mask", 32'(want.hit_mask), 32'(got.hit_mask));
               check_field("unhandled", 32'(want.unhandled), 32'(got.unhandled));
               check_field("frame_pgn", 32'(want.frame_pgn), 32'(got.frame_pgn));
               check_field("source_address", 32'(want.source_address),
                           32'(got.source_address));
               check_field("destination_address", 32'(want.destination_address),
                           32'(got.destination_address));
               check_field("zero fill", 32'(0),
                           32'(rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $error("no request or response moved for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      mode_type         m;
      req_data_type     rq;
      logic [7:0]       pf;
      logic [7:0]       ps;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_taken[k] = 1'b0;
         slot_group[k] = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         pf = 8'($urandom);
         ps = (pf >= PDU2_CUTOFF || $urandom_range(5) == 0) ? 8'($urandom) : 8'h00;
         group_pool[i] = {($urandom_range(7) == 0), 1'($urandom), pf, ps};
      end

      add_row(MODE_RECEIVE,    29'h00000000, 1'b1, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_RECEIVE,    29'h0CFEF123, 1'b0, 18'h00000, 8'd0,   1'b1, STAT_FILTERED, 8'd0);
      add_row(MODE_RECEIVE,    29'h02FEF123, 1'b1, 18'h00000, 8'd0,   1'b1, STAT_FILTERED, 8'd0);
      add_row(MODE_UNUSED,     29'h1FFFFFFF, 1'b1, 18'h3FFFF, 8'd255, 1'b1, STAT_OK, 8'd0);
      add_row(MODE_UNREGISTER, 29'h00000000, 1'b0, 18'h00000, 8'd0,   1'b1, STAT_BAD_SLOT, 8'd0);
      add_row(MODE_UNREGISTER, 29'h00000000, 1'b0, 18'h00000, 8'd255, 1'b1, STAT_BAD_SLOT, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h0FEF1, 8'd0,   1'b1, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h0EF00, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h0EF12, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h0FEF1, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h3FFFF, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h1FFFF, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h10000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h0FEF1, 8'd0,   1'b1, STAT_FULL, SLOT_NONE);
      add_row(MODE_RECEIVE,    29'h1CFEF123, 1'b1, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_RECEIVE,    29'h0CEF1280, 1'b1, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_RECEIVE,    29'h1FFFFFFF, 1'b1, 18'h00000, 8'd0,   1'b1, STAT_FILTERED, 8'd0);
      add_row(MODE_RECEIVE,    29'h1DFFFFFF, 1'b1, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_RECEIVE,    29'h00000000, 1'b1, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_UNREGISTER, 29'h00000000, 1'b0, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_UNREGISTER, 29'h00000000, 1'b0, 18'h00000, 8'd0,   1'b1, STAT_BAD_SLOT, 8'd0);
      add_row(MODE_UNREGISTER, 29'h00000000, 1'b0, 18'h00000, 8'd8,   1'b1, STAT_BAD_SLOT, 8'd0);
      add_row(MODE_REGISTER,   29'h00000000, 1'b0, 18'h0FEF1, 8'd0,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_UNREGISTER, 29'h00000000, 1'b0, 18'h00000, 8'd7,   1'b0, STAT_OK, 8'd0);
      add_row(MODE_RECEIVE,    29'h00F05501, 1'b1, 18'h00000, 8'd0,   1'b0, STAT_OK, 8'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].mode, directed_rows[i].request,
                      directed_rows[i].fixed, directed_rows[i].want);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            wait_all_responses();
            sender_idle_pct = 46;
            receiver_idle_pct = 38;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            wait_all_responses();
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         make_random(m, rq);
         send_request(m, rq, 1'b0, '0);
      end

      wait_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests across three handshake pacing phases.", requests_sent);
      $display("Frames: %0d matched, %0d unhandled, %0d filtered; %0d full, %0d bad slot.",
               hits_seen, unhandled_seen, filtered_seen, full_seen, bad_slot_seen);
      if (fail_count == 0 && pending_responses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
